/* sv/owbm_pkg.sv */
// Package for the 1-Wire bus master: opcodes, sequence phases,
// register indexes, reset values and port widths. No dependencies.
`default_nettype none

package owbm_pkg;

    localparam int BITS_PER_BYTE = 8;

    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [3:0] BYTE_BITS =
        ((BITS_PER_BYTE % 16) == 0) ? 4'd1 : 4'(BITS_PER_BYTE);

    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_RESET      = 3'd1,
        OP_WRITE_BYTE = 3'd2,
        OP_READ_BYTE  = 3'd3,
        OP_WRITE_BIT  = 3'd4,
        OP_READ_BIT   = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RLOW  = 2'd1,
        PH_RWAIT = 2'd2,
        PH_SLOT  = 2'd3
    } phase_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_LOW      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESENCE_SAMPLE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_TAIL     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_LOW      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_LOW       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_SAMPLE    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT           = 3'd6;

    localparam logic [9:0] RESET_LOW_DEFAULT       = 10'd480;
    localparam logic [9:0] PRESENCE_SAMPLE_DEFAULT = 10'd70;
    localparam logic [9:0] RESET_TAIL_DEFAULT      = 10'd410;
    localparam logic [6:0] SHORT_LOW_DEFAULT       = 7'd6;
    localparam logic [6:0] LONG_LOW_DEFAULT        = 7'd60;
    localparam logic [6:0] READ_SAMPLE_DEFAULT     = 7'd9;
    localparam logic [6:0] SLOT_DEFAULT            = 7'd70;

    localparam int OUT_LINE_LOW = 0;
    localparam int OUT_BUSY     = 1;
    localparam int OUT_DONE     = 2;
    localparam int OUT_PRESENCE = 3;
    localparam int OUT_IGNORED  = 12;

endpackage

`default_nettype wire

/* sv/one_wire_bus_master.sv */
// 1-Wire bus master, top level. Uses owbm_pkg.
// Each request is one microsecond tick: sampled line level plus an optional command.
//
// One request is taken per clock cycle and its result appears in the output
// register on the next cycle; the state update for a tick is one pass of logic
// between the sequence registers and that output register, so a new tick is
// accepted every cycle while the output register is empty or being read.
// Commands (reset, write/read byte, write/read bit) start only when idle; a command
// seen while busy is dropped and flagged in the result. The user must write timing
// registers through the cfg port only while no sequence runs; the block won't check.
`default_nettype none

module one_wire_bus_master (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [owbm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [owbm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [7:0] tx_byte, [8] line_in, [15:9] zero
    input  wire logic [owbm_pkg::S_TDATA_W-1:0]   s_tdata,
    // [2:0] opcode
    input  wire logic [owbm_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [0] line_low, [1] busy_res, [2] done_res, [3] presence,
    // [11:4] rx_byte, [12] cmd_ignored, [15:13] zero
    output logic [owbm_pkg::M_TDATA_W-1:0]        m_tdata
);
    import owbm_pkg::*;

    logic [9:0] reset_low_reg, presence_sample_reg, reset_tail_reg;
    logic [6:0] short_low_reg, long_low_reg, read_sample_reg, slot_reg;

    phase_t      phase_reg, phase_next;
    logic [10:0] tick_reg, tick_next;
    logic [3:0]  bits_reg, bits_next;
    logic [7:0]  shift_out_reg, shift_out_next;
    logic        reading_reg, reading_next;
    logic        presence_reg, presence_next;
    logic [7:0]  shift_in_reg, shift_in_next;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic       s_accept;
    opcode_t    opcode;
    logic [7:0] tx_byte;
    logic       line_in;
    logic       cmd;
    logic       start;
    logic       ignored;

    phase_t      eff_phase;
    logic [10:0] eff_tick;
    logic [3:0]  eff_bits;
    logic [7:0]  eff_shift_out;
    logic        eff_reading;
    logic [7:0]  eff_shift_in;

    logic [11:0] tick_inc;
    logic        rlow_last;
    logic [10:0] wait_len, wait_end, presence_pt;
    logic [6:0]  slot_end;
    logic [6:0]  low_time;
    logic [7:0]  read_pt_raw, read_pt;
    logic        slot_last;
    logic [3:0]  bits_dec;

    logic line_low, busy, done;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign opcode  = opcode_t'(s_tuser[2:0]);
    assign tx_byte = s_tdata[7:0];
    assign line_in = s_tdata[8];

    assign cmd = (opcode == OP_RESET) || (opcode == OP_WRITE_BYTE) ||
                 (opcode == OP_READ_BYTE) || (opcode == OP_WRITE_BIT) ||
                 (opcode == OP_READ_BIT);
    assign start   = (phase_reg == PH_IDLE) && cmd;
    assign ignored = (phase_reg != PH_IDLE) && cmd;

    // load a new command as tick 0 of its sequence
    always_comb begin
        eff_phase     = phase_reg;
        eff_tick      = tick_reg;
        eff_bits      = bits_reg;
        eff_shift_out = shift_out_reg;
        eff_reading   = reading_reg;
        eff_shift_in  = shift_in_reg;
        if (start) begin
            eff_tick = 11'd0;
            if (opcode == OP_RESET) begin
                eff_phase = PH_RLOW;
            end else begin
                eff_phase   = PH_SLOT;
                eff_reading = (opcode == OP_READ_BYTE) || (opcode == OP_READ_BIT);
                eff_bits    = ((opcode == OP_WRITE_BYTE) || (opcode == OP_READ_BYTE)) ?
                              BYTE_BITS : 4'd1;
                if (eff_reading) begin
                    eff_shift_in  = 8'd0;
                    eff_shift_out = 8'd1;
                end else if (opcode == OP_WRITE_BIT) begin
                    eff_shift_out = {7'd0, tx_byte[0]};
                end else begin
                    eff_shift_out = tx_byte;
                end
            end
        end
    end

    assign tick_inc    = {1'b0, eff_tick} + 12'd1;
    assign rlow_last   = tick_inc >= {2'd0, reset_low_reg};
    assign wait_len    = {1'b0, presence_sample_reg} + {1'b0, reset_tail_reg};
    assign wait_end    = (wait_len == 11'd0) ? 11'd0 : wait_len - 11'd1;
    assign presence_pt = ({1'b0, presence_sample_reg} < wait_end) ?
                         {1'b0, presence_sample_reg} : wait_end;
    assign slot_end    = (slot_reg == 7'd0) ? 7'd0 : slot_reg - 7'd1;
    assign low_time    = (eff_reading || eff_shift_out[0]) ? short_low_reg : long_low_reg;
    assign read_pt_raw = {1'b0, short_low_reg} + {1'b0, read_sample_reg};
    assign read_pt     = (read_pt_raw < {1'b0, slot_end}) ? read_pt_raw : {1'b0, slot_end};
    assign slot_last   = eff_tick >= {4'd0, slot_end};
    assign bits_dec    = eff_bits - 4'd1;

    always_comb begin
        phase_next     = eff_phase;
        tick_next      = eff_tick;
        bits_next      = eff_bits;
        shift_out_next = eff_shift_out;
        reading_next   = eff_reading;
        presence_next  = presence_reg;
        shift_in_next  = eff_shift_in;
        case (eff_phase)
            PH_IDLE: begin
            end
            PH_RLOW: begin
                if (rlow_last) begin
                    phase_next = PH_RWAIT;
                    tick_next  = 11'd0;
                end else begin
                    tick_next = tick_inc[10:0];
                end
            end
            PH_RWAIT: begin
                if (eff_tick == presence_pt) begin
                    presence_next = !line_in;
                end
                if (eff_tick >= wait_end) begin
                    phase_next = PH_IDLE;
                    tick_next  = 11'd0;
                end else begin
                    tick_next = tick_inc[10:0];
                end
            end
            PH_SLOT: begin
                if (eff_reading && (eff_tick == {3'd0, read_pt}) && line_in) begin
                    shift_in_next = eff_shift_in | eff_shift_out;
                end
                if (slot_last) begin
                    shift_out_next = eff_reading ? {eff_shift_out[6:0], 1'b0} :
                                                   {1'b0, eff_shift_out[7:1]};
                    bits_next = bits_dec;
                    tick_next = 11'd0;
                    if (bits_dec == 4'd0) begin
                        phase_next = PH_IDLE;
                    end
                end else begin
                    tick_next = tick_inc[10:0];
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        line_low = 1'b0;
        busy     = 1'b0;
        done     = 1'b0;
        case (eff_phase)
            PH_IDLE: begin
            end
            PH_RLOW: begin
                busy     = 1'b1;
                line_low = 1'b1;
            end
            PH_RWAIT: begin
                busy = 1'b1;
                done = eff_tick >= wait_end;
            end
            PH_SLOT: begin
                busy     = 1'b1;
                line_low = eff_tick < {4'd0, low_time};
                done     = slot_last && (bits_dec == 4'd0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_low_reg       <= RESET_LOW_DEFAULT;
            presence_sample_reg <= PRESENCE_SAMPLE_DEFAULT;
            reset_tail_reg      <= RESET_TAIL_DEFAULT;
            short_low_reg       <= SHORT_LOW_DEFAULT;
            long_low_reg        <= LONG_LOW_DEFAULT;
            read_sample_reg     <= READ_SAMPLE_DEFAULT;
            slot_reg            <= SLOT_DEFAULT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RESET_LOW:       reset_low_reg       <= cfg_data;
                CFG_PRESENCE_SAMPLE: presence_sample_reg <= cfg_data;
                CFG_RESET_TAIL:      reset_tail_reg      <= cfg_data;
                CFG_SHORT_LOW:       short_low_reg       <= cfg_data[6:0];
                CFG_LONG_LOW:        long_low_reg        <= cfg_data[6:0];
                CFG_READ_SAMPLE:     read_sample_reg     <= cfg_data[6:0];
                CFG_SLOT:            slot_reg            <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= 11'd0;
            bits_reg      <= 4'd0;
            shift_out_reg <= 8'd0;
            reading_reg   <= 1'b0;
            presence_reg  <= 1'b0;
            shift_in_reg  <= 8'd0;
        end else if (s_accept) begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bits_reg      <= bits_next;
            shift_out_reg <= shift_out_next;
            reading_reg   <= reading_next;
            presence_reg  <= presence_next;
            shift_in_reg  <= shift_in_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {3'd0, ignored, shift_in_next, presence_next, done, busy, line_low};
        end
    end

endmodule

`default_nettype wire

/* sv/owbm_check.sv */
// Port-level checks for the 1-Wire bus master, bound to one_wire_bus_master.
// Uses owbm_pkg for port widths and result bit positions.
`default_nettype none

module owbm_check (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [owbm_pkg::M_TDATA_W-1:0] m_tdata
);
    import owbm_pkg::*;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request refused with empty output");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[OUT_DONE] || m_tdata[OUT_LINE_LOW] || m_tdata[OUT_IGNORED])
        |-> m_tdata[OUT_BUSY])
        else $error("done, drive or drop flagged outside a sequence");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tdata[OUT_DONE] |=>
        !m_tvalid || !m_tdata[OUT_DONE] || m_tdata[OUT_IGNORED] == 1'b0 ||
        m_tdata[OUT_BUSY])
        else $error("result after done inconsistent");

endmodule

bind one_wire_bus_master owbm_check u_owbm_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
